### sv/piecewise_linear_contrast_macros.svh
// Assertion macros for the piecewise linear contrast block.
// Used by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef PIECEWISE_LINEAR_CONTRAST_MACROS_SVH
`define PIECEWISE_LINEAR_CONTRAST_MACROS_SVH

// Check on every rising clock edge, off while reset is asserted.
`define PLC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that holds in the cycle after a condition.
`define PLC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### sv/plc_pkg.sv
// Shared types and constants for the piecewise linear contrast pipeline.
// No dependencies; imported by every plc module and the top level.
`timescale 1ns / 1ps

package plc_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int NUM_BITS   = 2 * PIXEL_BITS;
	localparam int APB_BITS   = 32;
	localparam int ADDR_BITS  = 4;

	typedef logic [PIXEL_BITS-1:0] level_t;
	typedef logic [NUM_BITS-1:0]   num_t;

	localparam level_t LEVEL_MAX = '1;

	// register index codes (byte address / 4)
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_KNEE_IN_LOW   = 2'd0;
	localparam reg_idx_t REG_KNEE_OUT_LOW  = 2'd1;
	localparam reg_idx_t REG_KNEE_IN_HIGH  = 2'd2;
	localparam reg_idx_t REG_KNEE_OUT_HIGH = 2'd3;

	typedef struct packed {
		level_t r1;
		level_t s1;
		level_t r2;
		level_t s2;
	} knees_t;

	// segment operands: result = base + floor(+/-(a*b)/den)
	typedef struct packed {
		level_t a;
		level_t b;
		level_t den;
		level_t base;
		logic   neg;
	} seg_t;

	// divider state handed from cell to cell
	typedef struct packed {
		num_t   rem;
		level_t den;
		level_t quo;
		level_t base;
		logic   neg;
	} div_t;

endpackage

### sv/piecewise_linear_contrast.sv
// Piecewise linear contrast stretch of a gray pixel stream.
// Pixels enter on in_valid/in_ready with pixel_in; results leave on
// out_valid/out_ready with pixel_out, one result per pixel, in order.
// Knees are set through the APB port: knee_in_low at 0x0, knee_out_low at
// 0x4, knee_in_high at 0x8, knee_out_high at 0xC; write only while idle.
// Registered cells from an input transfer to out_valid: segment select,
// multiply, eight divider cells, output. Throughput: one pixel per cycle
// while out_ready stays high; each divider cell resolves one quotient bit.
// Every cell has its own valid bit and ready = !valid || downstream ready,
// so empty slots collapse; when the receiver stalls the chain fills up and
// in_ready drops only once every cell holds a pixel. While a result waits,
// new pixels are still taken as long as an empty cell remains.
// Reset (arst_n low) empties the chain and loads the knees with bypass
// values (0, 0, 255, 255), so pixels pass unchanged until configured.
// Depends on plc_pkg, the plc cells and the assertion macro header.
`timescale 1ns / 1ps
`include "piecewise_linear_contrast_macros.svh"

module piecewise_linear_contrast (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [plc_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [plc_pkg::APB_BITS-1:0]     pwdata,
	output logic [plc_pkg::APB_BITS-1:0]     prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [plc_pkg::PIXEL_BITS-1:0]   pixel_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [plc_pkg::PIXEL_BITS-1:0]   pixel_out
);
	import plc_pkg::*;

	knees_t   knees_q;
	reg_idx_t reg_idx;
	level_t   rd_level;
	logic     wr_en;

	seg_t seg_data;
	logic seg_valid;
	logic seg_ready;

	div_t div_data  [PIXEL_BITS+1];
	logic div_valid [PIXEL_BITS+1];
	logic div_ready [PIXEL_BITS+1];

	// ---- configuration ----
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knees_q <= '{r1: '0, s1: '0, r2: LEVEL_MAX, s2: LEVEL_MAX};
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KNEE_IN_LOW:   knees_q.r1 <= pwdata[PIXEL_BITS-1:0];
				REG_KNEE_OUT_LOW:  knees_q.s1 <= pwdata[PIXEL_BITS-1:0];
				REG_KNEE_IN_HIGH:  knees_q.r2 <= pwdata[PIXEL_BITS-1:0];
				REG_KNEE_OUT_HIGH: knees_q.s2 <= pwdata[PIXEL_BITS-1:0];
				default:           knees_q    <= knees_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KNEE_IN_LOW:   rd_level = knees_q.r1;
			REG_KNEE_OUT_LOW:  rd_level = knees_q.s1;
			REG_KNEE_IN_HIGH:  rd_level = knees_q.r2;
			REG_KNEE_OUT_HIGH: rd_level = knees_q.s2;
			default:           rd_level = '0;
		endcase
	end

	assign prdata = {{(APB_BITS-PIXEL_BITS){1'b0}}, rd_level};

	// ---- cell chain ----
	plc_seg_cell u_seg (
		.clk     (clk),
		.arst_n  (arst_n),
		.knees   (knees_q),
		.valid_i (in_valid),
		.pixel_i (pixel_in),
		.ready_o (in_ready),
		.valid_o (seg_valid),
		.data_o  (seg_data),
		.ready_i (seg_ready)
	);

	plc_mul_cell u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (seg_valid),
		.data_i  (seg_data),
		.ready_o (seg_ready),
		.valid_o (div_valid[0]),
		.data_o  (div_data[0]),
		.ready_i (div_ready[0])
	);

	for (genvar k = 0; k < PIXEL_BITS; k++) begin : g_div
		plc_div_cell #(
			.STEP (PIXEL_BITS - 1 - k)
		) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (div_valid[k]),
			.data_i  (div_data[k]),
			.ready_o (div_ready[k]),
			.valid_o (div_valid[k+1]),
			.data_o  (div_data[k+1]),
			.ready_i (div_ready[k+1])
		);
	end

	plc_out_cell u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (div_valid[PIXEL_BITS]),
		.data_i  (div_data[PIXEL_BITS]),
		.ready_o (div_ready[PIXEL_BITS]),
		.valid_o (out_valid),
		.pixel_o (pixel_out),
		.ready_i (out_ready)
	);

	// input side blocks only when the whole chain is full behind a stalled receiver
	`PLC_ASSERT(a_in_block, in_ready || (out_valid && !out_ready), "input blocked without stall")
	`PLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out),
		"waiting result changed")
	`PLC_ASSERT(a_pready_high, pready, "pready dropped")

endmodule

### sv/plc_seg_cell.sv
// First cell: picks the curve segment for a pixel and registers its operands.
// Depends on plc_pkg.
`timescale 1ns / 1ps

module plc_seg_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  plc_pkg::knees_t knees,
	input  logic            valid_i,
	input  plc_pkg::level_t pixel_i,
	output logic            ready_o,
	output logic            valid_o,
	output plc_pkg::seg_t   data_o,
	input  logic            ready_i
);
	import plc_pkg::*;

	logic valid_q;
	seg_t data_q;
	seg_t seg_d;
	logic bypass;

	assign bypass = (knees.r1 == knees.r2) || (knees.r1 == '0) || (knees.r2 == LEVEL_MAX);

	always_comb begin
		seg_d = '{a: '0, b: '0, den: level_t'(1), base: pixel_i, neg: 1'b0};
		priority if (bypass) begin
			// numerator zero, pixel passes through base
			seg_d.base = pixel_i;
		end else if (pixel_i <= knees.r1) begin
			seg_d.a    = pixel_i;
			seg_d.b    = knees.s1;
			seg_d.den  = knees.r1;
			seg_d.base = '0;
		end else if (pixel_i >= knees.r2) begin
			seg_d.a    = pixel_i - knees.r2;
			seg_d.b    = LEVEL_MAX - knees.s2;
			seg_d.den  = LEVEL_MAX - knees.r2;
			seg_d.base = knees.s2;
		end else begin
			// middle segment: when falling, divide the magnitude, floor fixed at the end
			seg_d.neg  = knees.s2 < knees.s1;
			seg_d.a    = pixel_i - knees.r1;
			seg_d.b    = seg_d.neg ? (knees.s1 - knees.s2) : (knees.s2 - knees.s1);
			seg_d.den  = knees.r2 - knees.r1;
			seg_d.base = knees.s1;
		end
	end

	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;
	assign data_o  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_q <= seg_d;
		end
	end

endmodule

### sv/plc_mul_cell.sv
// Multiplier cell: forms the segment numerator a*b for the divider chain.
// Depends on plc_pkg.
`timescale 1ns / 1ps

module plc_mul_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	input  plc_pkg::seg_t data_i,
	output logic          ready_o,
	output logic          valid_o,
	output plc_pkg::div_t data_o,
	input  logic          ready_i
);
	import plc_pkg::*;

	logic valid_q;
	div_t data_q;
	num_t prod;

	assign prod    = num_t'(data_i.a) * num_t'(data_i.b);
	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;
	assign data_o  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_q <= '{rem: prod, den: data_i.den, quo: '0, base: data_i.base,
				neg: data_i.neg};
		end
	end

endmodule

### sv/plc_div_cell.sv
// Restoring divider cell: resolves one quotient bit per pipeline step.
// Depends on plc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "piecewise_linear_contrast_macros.svh"

module plc_div_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	input  plc_pkg::div_t data_i,
	output logic          ready_o,
	output logic          valid_o,
	output plc_pkg::div_t data_o,
	input  logic          ready_i
);
	import plc_pkg::*;

	localparam level_t LOW_MASK = level_t'((1 << STEP) - 1);

	logic valid_q;
	div_t data_q;
	div_t next_d;
	num_t shifted;
	num_t shifted_q;
	logic take;

	assign shifted   = num_t'(data_i.den) << STEP;
	assign shifted_q = num_t'(data_q.den) << STEP;
	assign take      = data_i.rem >= shifted;

	always_comb begin
		next_d = data_i;
		next_d.quo[STEP] = take;
		if (take) begin
			next_d.rem = data_i.rem - shifted;
		end
	end

	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;
	assign data_o  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_q <= next_d;
		end
	end

	// quotient fits the pixel width, so the remainder stays below this cell's shifted divisor
	`PLC_ASSERT(a_rem_bound, !valid_q || (data_q.rem < shifted_q), "divider remainder too large")
	`PLC_ASSERT(a_quo_low, !valid_q || ((data_q.quo & LOW_MASK) == '0), "unresolved bits set")
	`PLC_ASSERT_NEXT(a_stall_hold, valid_q && !ready_i, valid_q && $stable(data_q),
		"stalled divider stage changed")

endmodule

### sv/plc_out_cell.sv
// Output cell: applies base and sign, with floor correction for falling segments.
// Depends on plc_pkg.
`timescale 1ns / 1ps

module plc_out_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_i,
	input  plc_pkg::div_t   data_i,
	output logic            ready_o,
	output logic            valid_o,
	output plc_pkg::level_t pixel_o,
	input  logic            ready_i
);
	import plc_pkg::*;

	logic                  valid_q;
	level_t                pixel_q;
	logic [PIXEL_BITS:0]   sum;
	logic [PIXEL_BITS:0]   round_up;

	// negative numerator: floor(-n/d) = -ceil(n/d)
	assign round_up = (data_i.rem != '0) ? (PIXEL_BITS+1)'(1) : '0;

	always_comb begin
		if (data_i.neg) begin
			sum = {1'b0, data_i.base} - {1'b0, data_i.quo} - round_up;
		end else begin
			sum = {1'b0, data_i.base} + {1'b0, data_i.quo};
		end
	end

	assign ready_o = !valid_q || ready_i;
	assign valid_o = valid_q;
	assign pixel_o = pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			pixel_q <= sum[PIXEL_BITS-1:0];
		end
	end

endmodule

### tb/sv/contrast_curve_check.sv
// Checker for piecewise_linear_contrast: tracks knee writes, predicts each pixel's mapped level.
// Compares every output transfer in order. Depends on plc_pkg only.
`timescale 1ns / 1ps

module contrast_curve_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [plc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [plc_pkg::APB_BITS-1:0]  pwdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  plc_pkg::level_t               pixel_in,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  plc_pkg::level_t               pixel_out,
	output int                            fail_count,
	output int                            expected_left,
	output int                            pixels_checked
);
	import plc_pkg::*;

	knees_t knees;
	level_t pending_levels[$];
	level_t want;

	// three-segment curve; quotients floor toward minus infinity
	function automatic level_t stretch_level(level_t p, knees_t k);
		int r1, s1, r2, s2, pix, top_lvl, num, den, base, q;
		r1 = int'(k.r1);
		s1 = int'(k.s1);
		r2 = int'(k.r2);
		s2 = int'(k.s2);
		pix = int'(p);
		top_lvl = int'(LEVEL_MAX);
		if (r1 == r2 || r1 == 0 || r2 == top_lvl)
			return p;
		if (pix <= r1) begin
			num = pix * s1;
			den = r1;
			base = 0;
		end else if (pix >= r2) begin
			num = (pix - r2) * (top_lvl - s2);
			den = top_lvl - r2;
			base = s2;
		end else begin
			num = (pix - r1) * (s2 - s1);
			den = r2 - r1;
			base = s1;
		end
		q = num / den;
		if (num % den != 0 && num < 0)
			q = q - 1;
		return level_t'(base + q);
	endfunction

	initial begin
		fail_count = 0;
		pixels_checked = 0;
		expected_left = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knees = '{r1: '0, s1: '0, r2: LEVEL_MAX, s2: LEVEL_MAX};
			pending_levels.delete();
			expected_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_levels.size() == 0) begin
					$error("pixel_out transfer with nothing pending: got %0d", pixel_out);
					fail_count++;
				end else begin
					want = pending_levels.pop_front();
					if (pixel_out !== want) begin
						$error("pixel_out mismatch: expected %0d, got %0d", want, pixel_out);
						fail_count++;
					end
					pixels_checked++;
				end
			end
			if (in_valid && in_ready)
				pending_levels.push_back(stretch_level(pixel_in, knees));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_KNEE_IN_LOW: knees.r1 = pwdata[PIXEL_BITS-1:0];
					REG_KNEE_OUT_LOW: knees.s1 = pwdata[PIXEL_BITS-1:0];
					REG_KNEE_IN_HIGH: knees.r2 = pwdata[PIXEL_BITS-1:0];
					REG_KNEE_OUT_HIGH: knees.s2 = pwdata[PIXEL_BITS-1:0];
					default: ;
				endcase
			end
			expected_left = pending_levels.size();
		end
	end

endmodule

### tb/sv/tb_piecewise_linear_contrast.sv
// Top testbench for piecewise_linear_contrast: clock, reset, APB knee writes, pixel stimulus.
// Depends on plc_pkg, the block and contrast_curve_check.
`timescale 1ns / 1ps

module tb_piecewise_linear_contrast;
	import plc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASES = 11;
	localparam int PIXELS_PER_PHASE = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [APB_BITS-1:0] pwdata = '0;
	logic in_valid = 1'b0;
	level_t pixel_in = '0;
	logic out_ready = 1'b0;
	wire [APB_BITS-1:0] prdata;
	wire pready;
	wire in_ready;
	wire out_valid;
	wire [PIXEL_BITS-1:0] pixel_out;

	int fail_count, expected_left, pixels_checked;
	int gap_odds = 0;
	int settings_used = 0;
	int stuck_cycles = 0;
	knees_t cur_knees = '{r1: '0, s1: '0, r2: LEVEL_MAX, s2: LEVEL_MAX};

	piecewise_linear_contrast dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out)
	);

	contrast_curve_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out),
		.fail_count(fail_count), .expected_left(expected_left),
		.pixels_checked(pixels_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog: cycles with no transfer on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (psel && penable && pwrite && pready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("tb_piecewise_linear_contrast failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// receiver: random stall bursts while gap_odds is nonzero
	initial begin
		@(posedge clk);
		forever begin
			if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input level_t v);
		logic [APB_BITS-1:0] w;
		w = $urandom();
		w[PIXEL_BITS-1:0] = v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold the sender until every pending pixel has come out
	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_left != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_knees(input level_t r1, s1, r2, s2);
		drain();
		write_reg(REG_KNEE_IN_LOW, r1);
		write_reg(REG_KNEE_OUT_LOW, s1);
		write_reg(REG_KNEE_IN_HIGH, r2);
		write_reg(REG_KNEE_OUT_HIGH, s2);
		cur_knees = '{r1: r1, s1: s1, r2: r2, s2: s2};
		settings_used++;
	endtask

	task automatic send_pixel(input level_t p);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic pick_knees(output level_t r1, s1, r2, s2);
		int mode;
		mode = $urandom_range(0, 9);
		s1 = level_t'($urandom_range(0, 255));
		s2 = level_t'($urandom_range(0, 255));
		case (mode)
			0: begin
				r1 = '0;
				r2 = level_t'($urandom_range(0, 255));
			end
			1: begin
				r1 = level_t'($urandom_range(0, 255));
				r2 = LEVEL_MAX;
			end
			2: begin
				r1 = level_t'($urandom_range(1, 254));
				r2 = r1;
			end
			3: begin
				// knees out of order
				r2 = level_t'($urandom_range(0, 253));
				r1 = level_t'($urandom_range(r2 + 1, 255));
			end
			4: begin
				r1 = $urandom_range(0, 1) ? 8'd1 : 8'd254;
				r2 = $urandom_range(0, 1) ? 8'd254 : 8'd1;
				s1 = $urandom_range(0, 1) ? 8'd0 : LEVEL_MAX;
				s2 = $urandom_range(0, 1) ? 8'd0 : LEVEL_MAX;
			end
			default: begin
				r1 = level_t'($urandom_range(1, 253));
				r2 = level_t'($urandom_range(r1 + 1, 254));
			end
		endcase
	endtask

	// bias toward the knees and the ends of the range
	function automatic level_t pick_pixel(knees_t k);
		case ($urandom_range(0, 7))
			0: return k.r1 + level_t'($urandom_range(0, 2)) - 8'd1;
			1: return k.r2 + level_t'($urandom_range(0, 2)) - 8'd1;
			2: return $urandom_range(0, 1) ? LEVEL_MAX : 8'd0;
			default: return level_t'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		level_t r1, s1, r2, s2;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset knees: bypass
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		// rising curve, edges of each segment
		set_knees(8'd64, 8'd32, 8'd192, 8'd224);
		send_pixel(8'd0);
		send_pixel(8'd64);
		send_pixel(8'd65);
		send_pixel(8'd191);
		send_pixel(8'd192);
		send_pixel(8'd255);
		// falling middle segment
		set_knees(8'd64, 8'd200, 8'd192, 8'd40);
		send_pixel(8'd100);
		send_pixel(8'd150);
		// knees out of order
		set_knees(8'd200, 8'd100, 8'd50, 8'd180);
		send_pixel(8'd10);
		send_pixel(8'd200);
		send_pixel(8'd201);
		send_pixel(8'd255);
		// extreme knees and levels
		set_knees(8'd1, 8'd255, 8'd254, 8'd0);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd2);
		send_pixel(8'd253);
		send_pixel(8'd254);
		send_pixel(8'd255);
		// equal input knees: bypass
		set_knees(8'd90, 8'd10, 8'd90, 8'd250);
		send_pixel(8'd33);

		for (int ph = 0; ph < PHASES; ph++) begin
			gap_odds = 0;
			pick_knees(r1, s1, r2, s2);
			set_knees(r1, s1, r2, s2);
			// no idling in the last phases
			if (ph < PHASES - 2)
				gap_odds = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 8 : 2;
			for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
				if (i == PIXELS_PER_PHASE / 2 && ph % 2 == 1)
					drain();
				send_pixel(pick_pixel(cur_knees));
			end
		end
		gap_odds = 0;
		drain();
		repeat (20) @(posedge clk);

		$display("Checked %0d pixels over %0d knee settings: bypass, rising, falling",
			pixels_checked, settings_used);
		$display("and out-of-order curves, with and without idle bursts on both sides.");
		if (fail_count == 0 && expected_left == 0) begin
			$display("tb_piecewise_linear_contrast passed");
		end else begin
			$display("tb_piecewise_linear_contrast failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/plc_pkg.sv
sv/plc_seg_cell.sv
sv/plc_mul_cell.sv
sv/plc_div_cell.sv
sv/plc_out_cell.sv
sv/piecewise_linear_contrast.sv
tb/sv/contrast_curve_check.sv
tb/sv/tb_piecewise_linear_contrast.sv
